[design/olrb_pkg.sv]
package olrb_pkg;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  tag;
    logic [31:0] value;
  } olrb_req_t;

  typedef struct packed {
    logic        pop_valid;
    logic [31:0] out_serial;
    logic [7:0]  out_tag;
    logic [31:0] out_value;
    logic        dropped_oldest;
    logic        now_empty;
    logic        now_full;
  } olrb_rsp_t;

  typedef struct packed {
    logic [31:0] serial;
    logic [7:0]  tag;
    logic [31:0] value;
  } olrb_rec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } olrb_state_e;

  typedef struct packed {
    logic capture;
    logic push;
    logic pop;
    logic rsp_valid;
  } olrb_cmd_t;

  typedef struct packed {
    logic is_pop;
    logic empty;
  } olrb_stat_t;

endpackage

[design/olrb_ctrl.sv]
module olrb_ctrl
  import olrb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  olrb_stat_t stat_i,
  output olrb_cmd_t  cmd_o,
  output logic       busy_o
);

  olrb_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy_o     = 1'b1;
        cmd_o.push = (stat_i.is_pop == OP_PUSH);
        // pop on an empty ring leaves the state alone
        cmd_o.pop  = (stat_i.is_pop == OP_POP) && !stat_i.empty;
        state_d    = ST_RESP;
      end
      ST_RESP: begin
        cmd_o.rsp_valid = 1'b1;
        // take the next request while the result is shown
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rsp_valid |-> $past(state_q) == ST_EXEC)
    else $error("result strobe without a preceding execute cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.push && cmd_o.pop))
    else $error("push and pop issued together");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> busy_o)
    else $error("captured request not executed next cycle");

endmodule

[design/olrb_dp.sv]
module olrb_dp
  import olrb_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  olrb_cmd_t  cmd_i,
  input  olrb_req_t  req_i,
  output olrb_stat_t stat_o,
  output olrb_rsp_t  rsp_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);

  olrb_rec_t     mem [DEPTH];
  olrb_rec_t     rd_q;
  olrb_req_t     req_q;
  logic [CW-1:0] fill_q, fill_d;
  logic [PW-1:0] head_q, head_d;
  logic [31:0]   serial_q;
  logic          pop_valid_q;
  logic          dropped_q;

  logic [PW-1:0] head_inc;
  logic [SW-1:0] slot_sum;
  logic [PW-1:0] slot_free;
  logic [PW-1:0] wr_addr;
  logic          full;
  logic          empty;
  olrb_rec_t     wr_rec;

  assign full     = (fill_q == FULL_CNT);
  assign empty    = (fill_q == '0);
  assign head_inc = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
  assign slot_sum = SW'(head_q) + SW'(fill_q) + SW'(1);
  assign slot_free = (slot_sum >= DEPTH_S) ? PW'(slot_sum - DEPTH_S) : PW'(slot_sum);
  // a full ring overwrites the oldest slot, just past the current head, which becomes the new head
  assign wr_addr  = full ? head_inc : slot_free;
  assign wr_rec   = '{serial: serial_q + 32'd1, tag: req_q.tag, value: req_q.value};

  always_comb begin
    fill_d = fill_q;
    head_d = head_q;
    if (cmd_i.push) begin
      if (full) begin
        head_d = head_inc;
      end else begin
        fill_d = fill_q + 1'b1;
      end
    end else if (cmd_i.pop) begin
      head_d = head_inc;
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      head_q      <= LAST_SLOT;
      serial_q    <= '0;
      pop_valid_q <= 1'b0;
      dropped_q   <= 1'b0;
    end else begin
      fill_q <= fill_d;
      head_q <= head_d;
      if (cmd_i.push) begin
        serial_q <= serial_q + 32'd1;
      end
      if (cmd_i.push || cmd_i.pop || (stat_o.is_pop == OP_POP && cmd_i.rsp_valid == 1'b0
          && !cmd_i.capture)) begin
        pop_valid_q <= cmd_i.pop;
        dropped_q   <= cmd_i.push && full;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (cmd_i.push) begin
      mem[wr_addr] <= wr_rec;
    end
    if (cmd_i.pop) begin
      rd_q <= mem[head_inc];
    end
  end

  assign stat_o.is_pop = req_q.opcode;
  assign stat_o.empty  = empty;

  always_comb begin
    rsp_o                = '0;
    rsp_o.pop_valid      = pop_valid_q;
    rsp_o.dropped_oldest = dropped_q;
    rsp_o.now_empty      = empty;
    rsp_o.now_full       = full;
    if (pop_valid_q) begin
      rsp_o.out_serial = rd_q.serial;
      rsp_o.out_tag    = rd_q.tag;
      rsp_o.out_value  = rd_q.value;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FULL_CNT)
    else $error("fill count beyond ring depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |=> (fill_q != '0) && (serial_q == $past(serial_q) + 32'd1))
    else $error("push did not store a record or advance the serial");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rsp_valid |-> !(pop_valid_q && dropped_q))
    else $error("result reports both a pop and a drop");

endmodule

[design/overwriting_log_ring_buffer.sv]
// Event log ring of DEPTH records. A request is taken when start is high and busy
// is low; opcode 0 stamps the tag and value with the next 32-bit serial (1 after
// reset, wrapping) and stores it, dropping the oldest record when the ring is
// full, and opcode 1 removes and returns the oldest record if the ring is not
// empty. Each request yields exactly one result, strobed by rsp_valid_o for one
// cycle: the strobe rises in the response state that follows the execute state
// after the request is taken; the receiver cannot stall it, so it must be
// captured then. A request passes through the execute state for the ring
// memory access (single write or registered read port) and the response state
// to show the result, during which the next request is already taken.
module overwriting_log_ring_buffer
  import olrb_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  olrb_req_t req_i,
  output logic      rsp_valid_o,
  output olrb_rsp_t rsp_o
);

  olrb_cmd_t  cmd;
  olrb_stat_t stat;

  olrb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  olrb_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .req_i (req_i),
    .stat_o(stat),
    .rsp_o (rsp_o)
  );

  assign rsp_valid_o = cmd.rsp_valid;

endmodule
